/* hdl/sml_pkg.sv */
// Shared types and constants for the sticky modifier latch.
package sml_pkg;

	// Key codes
	localparam logic [7:0] CODE_LSHIFT = 8'd42;
	localparam logic [7:0] CODE_RSHIFT = 8'd54;
	localparam logic [7:0] CODE_CTRL   = 8'd29;
	localparam logic [7:0] CODE_ALT    = 8'd56;
	localparam logic [7:0] CODE_META   = 8'd125;
	localparam logic [7:0] CODE_RELOAD = 8'd0;

	// Mask weights
	localparam logic [4:0] WEIGHT_SHIFT = 5'd1;
	localparam logic [4:0] WEIGHT_CTRL  = 5'd4;
	localparam logic [4:0] WEIGHT_ALT   = 5'd8;
	localparam logic [4:0] WEIGHT_META  = 5'd4;

	// Item function codes
	localparam logic FUNC_KEY    = 1'b0;
	localparam logic FUNC_RELOAD = 1'b1;

	// Shift mode codes
	localparam logic [1:0] SHIFT_OFF     = 2'd0;
	localparam logic [1:0] SHIFT_ONESHOT = 2'd1;
	localparam logic [1:0] SHIFT_LOCKED  = 2'd2;

	localparam logic [31:0] WINDOW_RESET = 32'd500000;

	localparam logic [4:0] MASK_MAX = 5'd17;

	typedef struct packed {
		logic [4:0]  mask_sum;
		logic        shift_oneshot;
		logic        shift_locked;
		logic [31:0] last_shift_press;
		logic        ctrl_latched;
		logic        alt_latched;
		logic        meta_latched;
	} latch_state_t;

	typedef struct packed {
		logic       func;
		logic [7:0] key_code;
		logic       key_down;
		logic [31:0] time_us;
	} key_item_t;

	typedef struct packed {
		logic       emit_valid;
		logic [7:0] emit_code;
		logic       emit_down;
		logic [4:0] modifier_mask;
		logic [1:0] shift_mode;
		logic       shift_shown;
		logic       layout_reload;
	} latch_result_t;

endpackage

/* hdl/sml_next.sv */
// Next-state and result logic for one key item.
module sml_next
	import sml_pkg::*;
(
	input  latch_state_t  st,
	input  key_item_t     item,
	input  logic [31:0]   window_us,
	output latch_state_t  nxt,
	output latch_result_t res
);

	logic [31:0] gap;
	logic        shift_key;
	logic        is_mod;
	logic        double_tap;

	assign gap        = item.time_us - st.last_shift_press;
	assign double_tap = st.shift_oneshot && (gap < window_us);
	assign shift_key  = (item.key_code == CODE_LSHIFT) || (item.key_code == CODE_RSHIFT);
	assign is_mod     = (item.key_code == CODE_CTRL) || (item.key_code == CODE_ALT)
		|| (item.key_code == CODE_META);

	always_comb begin
		nxt = st;
		res = '0;
		if (item.func == FUNC_RELOAD) begin
			nxt.mask_sum     = '0;
			nxt.ctrl_latched = 1'b0;
			nxt.alt_latched  = 1'b0;
			nxt.meta_latched = 1'b0;
			res.layout_reload = 1'b1;
		end else if (shift_key) begin
			if (item.key_down) begin
				nxt.last_shift_press = item.time_us;
				if (st.shift_locked) begin
					nxt.shift_locked  = 1'b0;
					nxt.shift_oneshot = 1'b0;
					nxt.mask_sum      = st.mask_sum & ~WEIGHT_SHIFT;
				end else if (double_tap) begin
					nxt.shift_oneshot = 1'b0;
					nxt.shift_locked  = 1'b1;
				end else if (st.shift_oneshot) begin
					nxt.shift_oneshot = 1'b0;
					nxt.mask_sum      = st.mask_sum & ~WEIGHT_SHIFT;
				end else begin
					nxt.shift_oneshot = 1'b1;
					nxt.mask_sum      = st.mask_sum | WEIGHT_SHIFT;
				end
			end
		end else if (is_mod) begin
			if (item.key_down) begin
				res.emit_valid = 1'b1;
				res.emit_code  = item.key_code;
				case (item.key_code)
					CODE_CTRL: begin
						nxt.ctrl_latched = !st.ctrl_latched;
						nxt.mask_sum = st.ctrl_latched ? st.mask_sum - WEIGHT_CTRL
							: st.mask_sum + WEIGHT_CTRL;
						res.emit_down = !st.ctrl_latched;
					end
					CODE_ALT: begin
						nxt.alt_latched = !st.alt_latched;
						nxt.mask_sum = st.alt_latched ? st.mask_sum - WEIGHT_ALT
							: st.mask_sum + WEIGHT_ALT;
						res.emit_down = !st.alt_latched;
					end
					default: begin
						nxt.meta_latched = !st.meta_latched;
						nxt.mask_sum = st.meta_latched ? st.mask_sum - WEIGHT_META
							: st.mask_sum + WEIGHT_META;
						res.emit_down = !st.meta_latched;
					end
				endcase
			end
		end else begin
			res.emit_valid = 1'b1;
			res.emit_code  = item.key_code;
			res.emit_down  = item.key_down;
			// any plain key uses up an armed one-shot
			if (st.shift_oneshot && !st.shift_locked) begin
				nxt.shift_oneshot = 1'b0;
				nxt.mask_sum      = st.mask_sum & ~WEIGHT_SHIFT;
			end
			if (!item.key_down && (item.key_code == CODE_RELOAD)) begin
				nxt.mask_sum      = '0;
				nxt.ctrl_latched  = 1'b0;
				nxt.alt_latched   = 1'b0;
				nxt.meta_latched  = 1'b0;
				res.layout_reload = 1'b1;
			end
		end
		res.modifier_mask = nxt.mask_sum;
		res.shift_shown   = nxt.mask_sum[0];
		if (nxt.shift_locked) begin
			res.shift_mode = SHIFT_LOCKED;
		end else if (nxt.shift_oneshot) begin
			res.shift_mode = SHIFT_ONESHOT;
		end else begin
			res.shift_mode = SHIFT_OFF;
		end
	end

endmodule

/* hdl/sticky_modifier_latch_core.sv */
// Top level of the sticky modifier latch: item pipeline, state and window register.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    func, key_code, key_down, time_us
//   out      output     out_valid / out_stall  emit_*, modifier_mask, shift_*, layout_reload
//   cfg      input      cfg_wr_en              cfg_wr_data (double-tap window, us)
//
// One item per cycle sustained while the output does not stall; an item passes the input
// register, then the result register where the latch state also updates.
// Reset clears the latch state, both valid flags and loads the 500000 us window.
// A stall on the output holds the result register and the input register; the
// input stalls only when its register is full and cannot move forward.
module sticky_modifier_latch_core
	import sml_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  key_code,
	input  logic        key_down,
	input  logic [31:0] time_us,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        emit_valid,
	output logic [7:0]  emit_code,
	output logic        emit_down,
	output logic [4:0]  modifier_mask,
	output logic [1:0]  shift_mode,
	output logic        shift_shown,
	output logic        layout_reload,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	logic          valid_s1;
	key_item_t     item_s1;
	logic          valid_s2;
	latch_result_t res_s2;
	latch_state_t  st_q;
	latch_state_t  st_nxt;
	latch_result_t res_nxt;
	logic [31:0]   window_q;
	logic          hold;
	logic          in_accept;

	// Result register is full and the consumer is not taking it.
	assign hold      = valid_s2 && out_stall;
	assign in_stall  = valid_s1 && hold;
	assign in_accept = in_valid && !in_stall;

	// Configuration: window register; users write it only while idle, unchecked here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	// Stage 1: capture the item whenever the slot is free or moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= '{func: func, key_code: key_code, key_down: key_down,
				time_us: time_us};
		end
	end

	sml_next u_next (
		.st        (st_q),
		.item      (item_s1),
		.window_us (window_q),
		.nxt       (st_nxt),
		.res       (res_nxt)
	);

	// Stage 2: advance the item into the result register and commit its state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else if (!hold) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign emit_valid    = res_s2.emit_valid;
	assign emit_code     = res_s2.emit_code;
	assign emit_down     = res_s2.emit_down;
	assign modifier_mask = res_s2.modifier_mask;
	assign shift_mode    = res_s2.shift_mode;
	assign shift_shown   = res_s2.shift_shown;
	assign layout_reload = res_s2.layout_reload;

`ifndef SYNTH
	// One-shot and lock are mutually exclusive.
	a_shift_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.shift_oneshot && st_q.shift_locked))
		else $error("shift one-shot and lock both set");

	// Additive mask never exceeds shift + ctrl + alt + meta.
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mask_sum <= MASK_MAX)
		else $error("modifier mask out of range");

	// A result without an event carries zero code and direction.
	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.emit_valid) |-> (res_s2.emit_code == '0 && !res_s2.emit_down))
		else $error("stray event payload");

	// A reload comes only from a reset item or a release of code zero.
	a_reload_src: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.layout_reload) |->
		(!res_s2.emit_valid || (res_s2.emit_code == CODE_RELOAD && !res_s2.emit_down)))
		else $error("reload from wrong item");

	// While the result is held, the latch state must not move.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> $stable(st_q))
		else $error("state changed under stall");
`endif

endmodule

/* tb/sv/sticky_modifier_latch_core_tb.sv */
// Self-checking testbench for the sticky modifier latch core: directed and random key items.
module sticky_modifier_latch_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sml_pkg::*;

	// Cycles with no item moved on either channel before the run is declared hung.
	// The longest legal quiet stretch comes from the receiver hold-off below.
	localparam int unsigned STALL_LIMIT   = 2000;
	// Length of the receiver hold-off that backs the block up into its input.
	localparam int unsigned HOLD_CYCLES   = 300;
	// Cycles to let pass after the last result: the core is two stages deep.
	localparam int unsigned SETTLE_CYCLES = 6;
	// Stop printing mismatch details after this many, keep counting.
	localparam int unsigned PRINT_CAP     = 40;

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Block inputs, all known from time zero
	logic        in_valid    = 1'b0;
	key_item_t   drv_item    = '0;
	logic        out_stall   = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [31:0] cfg_wr_data = '0;

	// Block outputs
	logic        in_stall;
	logic        out_valid;
	logic        emit_valid;
	logic [7:0]  emit_code;
	logic        emit_down;
	logic [4:0]  modifier_mask;
	logic [1:0]  shift_mode;
	logic        shift_shown;
	logic        layout_reload;

	sticky_modifier_latch_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (drv_item.func),
		.key_code      (drv_item.key_code),
		.key_down      (drv_item.key_down),
		.time_us       (drv_item.time_us),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.emit_valid    (emit_valid),
		.emit_code     (emit_code),
		.emit_down     (emit_down),
		.modifier_mask (modifier_mask),
		.shift_mode    (shift_mode),
		.shift_shown   (shift_shown),
		.layout_reload (layout_reload),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	// Stimulus and bookkeeping
	key_item_t     key_queue[$];       // items waiting to be offered
	latch_result_t latch_results[$];   // predicted results, oldest first
	int unsigned   n_queued    = 0;
	int unsigned   failures    = 0;
	int unsigned   quiet_count = 0;
	bit            in_taken    = 1'b0; // item accepted at the last rising edge
	bit            send_idle   = 1'b0; // sender inserts gaps
	bit            recv_idle   = 1'b0; // receiver inserts stalls
	bit            hold_req    = 1'b0; // ask the receiver for one long hold-off
	logic [31:0]   clock_us    = '0;   // running timestamp for random items

	// Predictor state: a private copy of the latch state and the tap window
	latch_state_t  latch_st   = '0;
	logic [31:0]   tap_window = WINDOW_RESET;

	// Gap length: mostly none, some short, a few long
	function automatic int unsigned pick_gap(bit enabled);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Add or remove a modifier weight depending on the new toggle state
	function automatic logic [4:0] step_weight(logic on, logic [4:0] weight);
		return on ? latch_st.mask_sum + weight : latch_st.mask_sum - weight;
	endfunction

	function automatic void clear_toggles();
		latch_st.mask_sum     = '0;
		latch_st.ctrl_latched = 1'b0;
		latch_st.alt_latched  = 1'b0;
		latch_st.meta_latched = 1'b0;
	endfunction

	// Advance the latch state by one item and return the result it produces
	function automatic latch_result_t apply_key_item(key_item_t it);
		latch_result_t r;
		logic [31:0]   gap;
		r = '0;
		if (it.func == FUNC_RELOAD) begin
			// Reset item: drop toggles, keep the shift flags and timestamp
			clear_toggles();
			r.layout_reload = 1'b1;
		end else if (it.key_code == CODE_LSHIFT || it.key_code == CODE_RSHIFT) begin
			// Shift release changes nothing
			if (it.key_down) begin
				gap = it.time_us - latch_st.last_shift_press; // wraps mod 2^32
				latch_st.last_shift_press = it.time_us;
				if (latch_st.shift_locked) begin
					latch_st.shift_locked  = 1'b0;
					latch_st.shift_oneshot = 1'b0;
					latch_st.mask_sum      = latch_st.mask_sum & ~WEIGHT_SHIFT;
				end else if (latch_st.shift_oneshot && gap < tap_window) begin
					latch_st.shift_oneshot = 1'b0;
					latch_st.shift_locked  = 1'b1;
				end else if (latch_st.shift_oneshot) begin
					latch_st.shift_oneshot = 1'b0;
					latch_st.mask_sum      = latch_st.mask_sum & ~WEIGHT_SHIFT;
				end else begin
					latch_st.shift_oneshot = 1'b1;
					latch_st.mask_sum      = latch_st.mask_sum | WEIGHT_SHIFT;
				end
			end
		end else if (it.key_code == CODE_CTRL || it.key_code == CODE_ALT ||
		             it.key_code == CODE_META) begin
			// Toggle on press, ignore release; a one-shot shift survives
			if (it.key_down) begin
				if (it.key_code == CODE_CTRL) begin
					latch_st.ctrl_latched = !latch_st.ctrl_latched;
					latch_st.mask_sum     = step_weight(latch_st.ctrl_latched, WEIGHT_CTRL);
					r.emit_down           = latch_st.ctrl_latched;
				end else if (it.key_code == CODE_ALT) begin
					latch_st.alt_latched = !latch_st.alt_latched;
					latch_st.mask_sum    = step_weight(latch_st.alt_latched, WEIGHT_ALT);
					r.emit_down          = latch_st.alt_latched;
				end else begin
					latch_st.meta_latched = !latch_st.meta_latched;
					latch_st.mask_sum     = step_weight(latch_st.meta_latched, WEIGHT_META);
					r.emit_down           = latch_st.meta_latched;
				end
				r.emit_valid = 1'b1;
				r.emit_code  = it.key_code;
			end
		end else begin
			// Plain key: forward it and use up an armed one-shot
			r.emit_valid = 1'b1;
			r.emit_code  = it.key_code;
			r.emit_down  = it.key_down;
			if (latch_st.shift_oneshot && !latch_st.shift_locked) begin
				latch_st.shift_oneshot = 1'b0;
				latch_st.mask_sum      = latch_st.mask_sum & ~WEIGHT_SHIFT;
			end
			// Releasing code 0 doubles as a reset request
			if (!it.key_down && it.key_code == CODE_RELOAD) begin
				clear_toggles();
				r.layout_reload = 1'b1;
			end
		end
		r.modifier_mask = latch_st.mask_sum;
		r.shift_mode    = latch_st.shift_locked  ? SHIFT_LOCKED :
		                  latch_st.shift_oneshot ? SHIFT_ONESHOT : SHIFT_OFF;
		r.shift_shown   = latch_st.mask_sum[0];
		return r;
	endfunction

	task automatic add_key(logic f, logic [7:0] code, logic down, logic [31:0] t);
		key_item_t it;
		it.func     = f;
		it.key_code = code;
		it.key_down = down;
		it.time_us  = t;
		key_queue.push_back(it);
		n_queued++;
	endtask

	function automatic logic [7:0] pick_modifier();
		case ($urandom_range(0, 2))
			0: return CODE_CTRL;
			1: return CODE_ALT;
			default: return CODE_META;
		endcase
	endfunction

	function automatic logic [7:0] pick_shift();
		return $urandom_range(0, 1) ? CODE_LSHIFT : CODE_RSHIFT;
	endfunction

	// Gap between two shift presses: inside the window or at/after its edge
	function automatic logic [31:0] pick_tap_gap();
		if (tap_window != 0 && $urandom_range(0, 1))
			return $urandom_range(0, tap_window - 1);
		return tap_window + $urandom_range(0, 3000);
	endfunction

	task automatic report_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			if (failures < PRINT_CAP)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
			failures++;
		end
	endtask

	// Short directed run at the reset window: every special case once
	task automatic queue_directed();
		// Reset item with every other field at its top value
		add_key(FUNC_RELOAD, 8'hFF, 1'b1, 32'hFFFF_FFFF);
		// Arm, then a plain key consumes the one-shot
		add_key(FUNC_KEY, CODE_LSHIFT, 1'b1, 32'd100);
		add_key(FUNC_KEY, 8'd30, 1'b1, 32'd150);
		add_key(FUNC_KEY, 8'd30, 1'b0, 32'd160);
		// Arm, shift release, double tap just inside the window, locked key, unlock
		add_key(FUNC_KEY, CODE_LSHIFT, 1'b1, 32'd1000);
		add_key(FUNC_KEY, CODE_LSHIFT, 1'b0, 32'd1100);
		add_key(FUNC_KEY, CODE_RSHIFT, 1'b1, 32'd500999);
		add_key(FUNC_KEY, 8'd30, 1'b1, 32'd501000);
		add_key(FUNC_KEY, CODE_LSHIFT, 1'b1, 32'd600000);
		// Second press exactly at the window edge disarms
		add_key(FUNC_KEY, CODE_LSHIFT, 1'b1, 32'd2000000);
		add_key(FUNC_KEY, CODE_RSHIFT, 1'b1, 32'd2500000);
		// All toggles plus shift: mask peaks at 17, then release of code 0 clears
		add_key(FUNC_KEY, CODE_CTRL, 1'b1, 32'd3000000);
		add_key(FUNC_KEY, CODE_ALT, 1'b1, 32'd3000001);
		add_key(FUNC_KEY, CODE_META, 1'b1, 32'd3000002);
		add_key(FUNC_KEY, CODE_LSHIFT, 1'b1, 32'd3000003);
		add_key(FUNC_KEY, CODE_CTRL, 1'b0, 32'd3000004);
		add_key(FUNC_KEY, CODE_CTRL, 1'b1, 32'd3000005);
		add_key(FUNC_KEY, CODE_RELOAD, 1'b0, 32'd3000006);
		add_key(FUNC_KEY, CODE_RELOAD, 1'b1, 32'd3000007);
		// Double tap across the timestamp wrap, then unlock
		add_key(FUNC_KEY, CODE_LSHIFT, 1'b1, 32'hFFFF_FF00);
		add_key(FUNC_KEY, CODE_RSHIFT, 1'b1, 32'h0000_0100);
		add_key(FUNC_KEY, CODE_LSHIFT, 1'b1, 32'h0000_0200);
		// Top key code
		add_key(FUNC_KEY, 8'hFF, 1'b1, 32'hFFFF_FFFF);
		add_key(FUNC_KEY, 8'hFF, 1'b0, 32'h0000_0000);
	endtask

	// Random sequences: mostly well-formed typing with shift taps, some noise
	task automatic queue_random(int unsigned count);
		int unsigned target;
		int unsigned pick;
		logic [7:0]  code;
		target = n_queued + count;
		while (n_queued < target) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0)
				clock_us = $urandom();
			else
				clock_us += $urandom_range(1, 2000);
			if (pick < 30) begin
				// Shift tap pair, optionally with release and a modifier in between
				add_key(FUNC_KEY, pick_shift(), 1'b1, clock_us);
				if ($urandom_range(0, 9) < 4)
					add_key(FUNC_KEY, pick_shift(), 1'b0, clock_us);
				if ($urandom_range(0, 9) < 3)
					add_key(FUNC_KEY, pick_modifier(), 1'b1, clock_us);
				clock_us += pick_tap_gap();
				add_key(FUNC_KEY, pick_shift(), 1'b1, clock_us);
				if ($urandom_range(0, 9) < 3) begin
					clock_us += pick_tap_gap();
					add_key(FUNC_KEY, pick_shift(), 1'b1, clock_us);
				end
				code = 8'($urandom_range(1, 255));
				add_key(FUNC_KEY, code, 1'b1, clock_us);
				add_key(FUNC_KEY, code, 1'b0, clock_us + 1);
			end else if (pick < 50) begin
				// Modifier press and release, sometimes followed by another modifier press
				code = pick_modifier();
				add_key(FUNC_KEY, code, 1'b1, clock_us);
				add_key(FUNC_KEY, code, 1'b0, clock_us);
				if ($urandom_range(0, 1))
					add_key(FUNC_KEY, pick_modifier(), 1'b1, clock_us);
			end else if (pick < 75) begin
				// Plain key press and release
				code = 8'($urandom_range(1, 255));
				add_key(FUNC_KEY, code, 1'b1, clock_us);
				add_key(FUNC_KEY, code, 1'b0, clock_us);
			end else if (pick < 85) begin
				// Either form of reset request
				if ($urandom_range(0, 1))
					add_key(FUNC_RELOAD, 8'($urandom_range(0, 255)),
					        1'($urandom_range(0, 1)), $urandom());
				else
					add_key(FUNC_KEY, CODE_RELOAD, 1'b0, clock_us);
			end else begin
				// Noise: every field random
				add_key(1'($urandom_range(0, 9) == 0), 8'($urandom_range(0, 255)),
				        1'($urandom_range(0, 1)), $urandom());
			end
		end
	endtask

	// Wait until nothing is queued, in flight or expected, then let the pipe settle
	task automatic drain();
		while (key_queue.size() != 0 || in_valid || latch_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the tap window while the block is idle; keep the predictor in step
	task automatic set_tap_window(logic [31:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		tap_window   = value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Sender: offer the next item after acceptance, hold a stalled one steady
	int unsigned send_gap = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (send_gap != 0 || key_queue.size() == 0) begin
					in_valid <= 1'b0;
					if (send_gap != 0)
						send_gap--;
				end else begin
					drv_item <= key_queue.pop_front();
					in_valid <= 1'b1;
					send_gap  = pick_gap(send_idle);
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	int unsigned stall_left = 0;
	int unsigned hold_left  = 0;

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap(recv_idle);
		end
	end

	// Monitor: predict on input acceptance, compare on output acceptance, watch for hangs
	always @(posedge clk) begin
		latch_result_t want;
		bit            out_taken;
		in_taken  = arst_n && in_valid && !in_stall;
		out_taken = arst_n && out_valid && !out_stall;
		if (in_taken)
			latch_results.push_back(apply_key_item(drv_item));
		if (out_taken) begin
			if (latch_results.size() == 0) begin
				if (failures < PRINT_CAP)
					$display("%0t: result with nothing expected, actual code %0h mask %0h",
					         $time, emit_code, modifier_mask);
				failures++;
			end else begin
				want = latch_results.pop_front();
				report_field("emit_valid", 32'(want.emit_valid), 32'(emit_valid));
				report_field("emit_code", 32'(want.emit_code), 32'(emit_code));
				report_field("emit_down", 32'(want.emit_down), 32'(emit_down));
				report_field("modifier_mask", 32'(want.modifier_mask), 32'(modifier_mask));
				report_field("shift_mode", 32'(want.shift_mode), 32'(shift_mode));
				report_field("shift_shown", 32'(want.shift_shown), 32'(shift_shown));
				report_field("layout_reload", 32'(want.layout_reload), 32'(layout_reload));
			end
		end
		quiet_count = (in_taken || out_taken) ? 0 : quiet_count + 1;
		if (quiet_count >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Test sequence
	logic [31:0] tap_settings [6] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1000, 32'd0, WINDOW_RESET};

	initial begin
		logic [31:0] window;
		// Hold reset, then release it away from the clock edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset window, with idling on both sides
		send_idle = 1'b1;
		recv_idle = 1'b1;
		queue_directed();
		drain();

		// Random phases across window settings; the fifth uses a random window
		clock_us = 32'd4000000;
		for (int i = 0; i < 6; i++) begin
			window = (i == 4) ? $urandom() : tap_settings[i];
			set_tap_window(window);
			send_idle = i[0];
			recv_idle = i[1];
			queue_random(95);
			drain();
		end

		// Back-pressure: sender streams back to back while the receiver holds off
		send_idle = 1'b0;
		recv_idle = 1'b1;
		hold_req  = 1'b1;
		queue_random(40);
		drain();

		if (failures == 0 && latch_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0t: %0d mismatches, %0d results missing", $time, failures,
			         latch_results.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
